@@ design/apr_pkg.sv @@
`default_nettype none

package apr_pkg;

  localparam int BUFFER_BYTES_DEF = 65536;

  typedef enum logic [1:0] {
    CMD_REG_WRITE    = 2'd0,
    CMD_REG_READ     = 2'd1,
    CMD_SAMPLE_WRITE = 2'd2,
    CMD_PULL         = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    IDX_RATE     = 3'd0,
    IDX_CHANNELS = 3'd1,
    IDX_SAMPLES  = 3'd2,
    IDX_SIZE     = 3'd3,
    IDX_INIT     = 3'd4,
    IDX_COUNT    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_byte;
    logic        rd_en;
  } ring_ctl_t;

endpackage

`default_nettype wire

@@ design/apr_ifs.sv @@
`default_nettype none

interface apr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  reg_index;
  logic [31:0] reg_data;
  logic [15:0] buf_addr;
  logic [7:0]  buf_byte;

  modport source (
    output valid, command, reg_index, reg_data, buf_addr, buf_byte,
    input  ready
  );
  modport sink (
    input  valid, command, reg_index, reg_data, buf_addr, buf_byte,
    output ready
  );
endinterface

interface apr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [7:0]  play_byte;
  logic        play_valid;
  logic        count_overflow;

  modport source (
    output valid, read_data, play_byte, play_valid, count_overflow,
    input  ready
  );
  modport sink (
    input  valid, read_data, play_byte, play_valid, count_overflow,
    output ready
  );
endinterface

`default_nettype wire

@@ design/apr_ring.sv @@
`default_nettype none

module apr_ring import apr_pkg::*; #(
  parameter  int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk,
  input  wire ring_ctl_t     ctl,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_byte
);

  logic [7:0]  mem [BUFFER_BYTES];
  logic [31:0] waddr_ext;

  assign waddr_ext = 32'(ctl.wr_addr);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr_ext[AW-1:0]] <= ctl.wr_byte;
    end
    if (ctl.rd_en) begin
      rd_byte <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/apr_regs.sv @@
`default_nettype none

module apr_regs import apr_pkg::*; #(
  parameter  int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [1:0]  command,
  input  wire logic [2:0]  reg_index,
  input  wire logic [31:0] reg_data,
  input  wire logic [15:0] buf_addr,
  input  wire logic [7:0]  buf_byte,
  output ring_ctl_t        ring_ctl,
  output logic [AW-1:0]    rd_addr,
  output logic [31:0]      read_data,
  output logic             play_valid,
  output logic             count_overflow
);

  logic [31:0]   rate_word;
  logic [31:0]   channel_word;
  logic [31:0]   samples_word;
  logic [31:0]   init_word;
  logic          playing;
  logic [CW-1:0] pending_count;
  logic [AW-1:0] read_position;

  cmd_t          cmd;
  reg_idx_t      idx;
  logic [32:0]   count_sum;
  logic          count_sat;
  logic          count_wr;
  logic          pull_ok;
  logic [AW:0]   pos_inc;
  logic [AW-1:0] read_position_next;
  logic [31:0]   addr_ext;
  logic          addr_ok;
  logic [31:0]   reg_value;

  assign cmd       = cmd_t'(command);
  assign idx       = reg_idx_t'(reg_index);
  assign count_sum = 33'(pending_count) + 33'(reg_data);
  assign count_sat = count_sum > 33'(BUFFER_BYTES);
  assign count_wr  = (cmd == CMD_REG_WRITE) && (idx == IDX_COUNT);
  assign pull_ok   = (cmd == CMD_PULL) && playing && (pending_count != '0);
  assign pos_inc   = (AW+1)'(read_position) + (AW+1)'(1);
  assign read_position_next =
    (pos_inc == (AW+1)'(BUFFER_BYTES)) ? '0 : pos_inc[AW-1:0];
  assign addr_ext  = 32'(buf_addr);
  assign addr_ok   = addr_ext < 32'(BUFFER_BYTES);

  always_comb begin
    unique case (idx)
      IDX_RATE:     reg_value = rate_word;
      IDX_CHANNELS: reg_value = channel_word;
      IDX_SAMPLES:  reg_value = samples_word;
      IDX_SIZE:     reg_value = 32'(BUFFER_BYTES);
      IDX_INIT:     reg_value = init_word;
      IDX_COUNT:    reg_value = 32'(pending_count);
      default:      reg_value = '0;
    endcase
  end

  assign ring_ctl.wr_en   = accept && (cmd == CMD_SAMPLE_WRITE) && addr_ok;
  assign ring_ctl.wr_addr = buf_addr;
  assign ring_ctl.wr_byte = buf_byte;
  assign ring_ctl.rd_en   = accept && pull_ok;
  assign rd_addr          = read_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_word     <= '0;
      channel_word  <= '0;
      samples_word  <= '0;
      init_word     <= '0;
      playing       <= 1'b0;
      pending_count <= '0;
      read_position <= '0;
    end else if (accept) begin
      unique case (cmd)
        CMD_REG_WRITE: begin
          unique case (idx)
            IDX_RATE:     rate_word    <= reg_data;
            IDX_CHANNELS: channel_word <= reg_data;
            IDX_SAMPLES:  samples_word <= reg_data;
            IDX_INIT: begin
              init_word <= reg_data;
              if (reg_data == 32'd1) begin
                playing <= 1'b1;
              end
            end
            IDX_COUNT: begin
              pending_count <= count_sat ? CW'(BUFFER_BYTES) : count_sum[CW-1:0];
            end
            default: ;
          endcase
        end
        CMD_PULL: begin
          if (pull_ok) begin
            pending_count <= pending_count - CW'(1);
            read_position <= read_position_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= (cmd == CMD_REG_READ) ? reg_value : '0;
      play_valid     <= pull_ok;
      count_overflow <= count_wr && count_sat;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= CW'(BUFFER_BYTES))
    else $error("pending count above buffer size");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(read_position) < 32'(BUFFER_BYTES))
    else $error("play position outside buffer");

  a_pull_dec: assert property (@(posedge clk) disable iff (rst)
    accept && pull_ok |=> pending_count == $past(pending_count) - CW'(1))
    else $error("pull did not consume one pending byte");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    accept && count_wr && count_sat |=>
      count_overflow && (pending_count == CW'(BUFFER_BYTES)))
    else $error("saturating count write not flagged");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    accept |=> !(play_valid && count_overflow))
    else $error("pull and overflow flagged in one result");

endmodule

`default_nettype wire

@@ design/audio_playback_ring_device_top.sv @@
`default_nettype none

// channel  modport  moves
// -------  -------  ----------------------------------------------
// req      sink     request: register access, sample write or pull
// rsp      source   one result per request
//
// one request per cycle while results are taken; its result is valid the cycle after acceptance
// the sample buffer read port registers the pulled byte into the result
// rst clears the register file, play state, pending count and position
// the buffer itself is not cleared; unwritten bytes read as anything
// a stalled result holds and blocks new requests until it is taken

module audio_playback_ring_device_top import apr_pkg::*; #(
  parameter  int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic  clk,
  input  wire logic  rst,
  apr_req_if.sink    req,
  apr_rsp_if.source  rsp
);

  logic          out_valid;
  logic          accept;
  ring_ctl_t     ring_ctl;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ring_byte;
  logic          play_valid;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  apr_regs #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_regs (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (req.command),
    .reg_index      (req.reg_index),
    .reg_data       (req.reg_data),
    .buf_addr       (req.buf_addr),
    .buf_byte       (req.buf_byte),
    .ring_ctl       (ring_ctl),
    .rd_addr        (rd_addr),
    .read_data      (rsp.read_data),
    .play_valid     (play_valid),
    .count_overflow (rsp.count_overflow)
  );

  apr_ring #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ring (
    .clk     (clk),
    .ctl     (ring_ctl),
    .rd_addr (rd_addr),
    .rd_byte (ring_byte)
  );

  assign rsp.valid      = out_valid;
  assign rsp.play_valid = play_valid;
  assign rsp.play_byte  = play_valid ? ring_byte : '0;

endmodule

`default_nettype wire

@@ sim/audio_playback_ring_device_top_tb.sv @@
`timescale 1ns / 100ps

module audio_playback_ring_device_top_tb;
  import apr_pkg::*;

  localparam int         RING_BYTES   = BUFFER_BYTES_DEF;
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  localparam int         RANDOM_ITEMS = 1830;
  localparam int         LONG_HOLD    = 200;
  localparam int         CYCLE_LIMIT  = 100_000;
  localparam int         MAX_REPORTS  = 20;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  play_byte;
    logic        play_valid;
    logic        count_overflow;
  } dev_result_t;

  logic clk;
  logic rst        = 1'b1;
  logic idle_on    = 1'b1;
  logic hold_start = 1'b0;
  int   hold_left  = 0;
  int   rsp_gap    = 0;
  int   rsp_gap_next;
  int   cycle_count = 0;
  int   mismatches  = 0;
  int   items_sent  = 0;

  // device state as of the last accepted request
  logic [31:0] rate_q    = '0;
  logic [31:0] chan_q    = '0;
  logic [31:0] samples_q = '0;
  logic [31:0] init_q    = '0;
  logic        play_on   = 1'b0;
  logic [16:0] pending_q = '0;
  logic [15:0] play_ptr  = '0;
  logic [7:0]  ring_mem     [RING_BYTES];
  bit          ring_written [RING_BYTES];

  dev_result_t result_q [$];

  apr_req_if req ();
  apr_rsp_if rsp ();

  audio_playback_ring_device_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic dev_result_t next_device_result(input cmd_t cmd, input logic [2:0] idx,
      input logic [31:0] data, input logic [15:0] addr, input logic [7:0] sample);
    dev_result_t res;
    logic [32:0] total;
    res = '0;
    case (cmd)
      CMD_REG_WRITE: begin
        case (idx)
          IDX_RATE:     rate_q = data;
          IDX_CHANNELS: chan_q = data;
          IDX_SAMPLES:  samples_q = data;
          IDX_INIT: begin
            init_q = data;
            if (data == 32'd1) play_on = 1'b1;
          end
          IDX_COUNT: begin
            total = 33'(pending_q) + 33'(data);
            if (total > 33'(RING_BYTES)) begin
              pending_q = 17'(RING_BYTES);
              res.count_overflow = 1'b1;
            end else begin
              pending_q = total[16:0];
            end
          end
          default: ;
        endcase
      end
      CMD_REG_READ: begin
        case (idx)
          IDX_RATE:     res.read_data = rate_q;
          IDX_CHANNELS: res.read_data = chan_q;
          IDX_SAMPLES:  res.read_data = samples_q;
          IDX_SIZE:     res.read_data = 32'(RING_BYTES);
          IDX_INIT:     res.read_data = init_q;
          IDX_COUNT:    res.read_data = 32'(pending_q);
          default:      res.read_data = '0;
        endcase
      end
      CMD_SAMPLE_WRITE: begin
        if (int'(addr) < RING_BYTES) begin
          ring_mem[addr]     = sample;
          ring_written[addr] = 1'b1;
        end
      end
      default: begin
        if (play_on && pending_q != 0) begin
          res.play_byte  = ring_mem[play_ptr];
          res.play_valid = 1'b1;
          play_ptr       = 16'((int'(play_ptr) + 1) % RING_BYTES);
          pending_q      = pending_q - 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_result();
    dev_result_t got;
    dev_result_t want;
    got = {rsp.read_data, rsp.play_byte, rsp.play_valid, rsp.count_overflow};
    if (result_q.size() == 0) begin
      report($sformatf("result %h with no request outstanding", got));
    end else begin
      want = result_q.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.play_byte !== want.play_byte)
        report($sformatf("play_byte %h, want %h", got.play_byte, want.play_byte));
      if (got.play_valid !== want.play_valid)
        report($sformatf("play_valid %b, want %b", got.play_valid, want.play_valid));
      if (got.count_overflow !== want.count_overflow)
        report($sformatf("count_overflow %b, want %b", got.count_overflow,
                         want.count_overflow));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_gap   <= 0;
    end else begin
      rsp_gap_next = rsp_gap;
      if (rsp.valid && rsp.ready) begin
        check_result();
        rsp_gap_next = idle_on ? $urandom_range(0, 3) : 0;
      end else if (rsp_gap_next != 0) begin
        rsp_gap_next = rsp_gap_next - 1;
      end
      rsp_gap   <= rsp_gap_next;
      rsp.ready <= (rsp_gap_next == 0) && (hold_left == 0);
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [2:0] idx, input logic [31:0] data,
      input logic [15:0] addr, input logic [7:0] sample);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.reg_index <= idx;
    req.reg_data  <= data;
    req.buf_addr  <= addr;
    req.buf_byte  <= sample;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    result_q.push_back(next_device_result(cmd, idx, data, addr, sample));
    items_sent++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    send_request(CMD_REG_WRITE, idx, data, 16'($urandom()), 8'($urandom()));
  endtask

  task automatic reg_read(input logic [2:0] idx);
    send_request(CMD_REG_READ, idx, $urandom(), 16'($urandom()), 8'($urandom()));
  endtask

  task automatic sample_write(input logic [15:0] addr, input logic [7:0] sample);
    send_request(CMD_SAMPLE_WRITE, 3'($urandom()), $urandom(), addr, sample);
  endtask

  // never let a pull land on a byte that was never written
  task automatic pull_byte();
    if (play_on && pending_q != 0 && !ring_written[play_ptr])
      sample_write(play_ptr, 8'($urandom()));
    send_request(CMD_PULL, 3'($urandom()), $urandom(), 16'($urandom()), 8'($urandom()));
  endtask

  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) reg_read(3'(i));
  endtask

  task automatic test_playback_gating();
    pull_byte();
    reg_write(IDX_COUNT, 32'd2);
    pull_byte();
    reg_write(IDX_INIT, 32'hFFFF_FFFF);
    pull_byte();
    sample_write(16'h0000, 8'hFF);
    sample_write(16'h0001, 8'h00);
    reg_write(IDX_INIT, 32'd1);
    repeat (3) pull_byte();
  endtask

  task automatic test_register_extremes();
    reg_write(IDX_RATE, '1);
    reg_write(IDX_SAMPLES, '1);
    reg_write(IDX_SIZE, 32'd0);
    reg_write(IDX_SPARE_HI, '1);
    reg_write(IDX_COUNT, 32'(RING_BYTES - 1));
    reg_write(IDX_COUNT, 32'd1);
    reg_write(IDX_COUNT, 32'd1);
    reg_write(IDX_COUNT, '1);
    reg_read(IDX_RATE);
    reg_read(IDX_SAMPLES);
    reg_read(IDX_SIZE);
    reg_read(IDX_COUNT);
    reg_read(IDX_SPARE_HI);
  endtask

  task automatic test_random_traffic();
    int          first;
    int          toggled;
    int          n;
    int          pick;
    logic [2:0]  idx;
    logic [31:0] data;
    logic        late;
    first   = items_sent;
    toggled = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      late = (items_sent - first) > RANDOM_ITEMS * 85 / 100;
      if (items_sent - toggled >= 150) begin
        idle_on <= ($urandom_range(0, 2) != 0);
        toggled = items_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // stream chunk: queue bytes behind the pending ones, bump count, play them
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
          sample_write(16'((int'(play_ptr) + int'(pending_q) + k) % RING_BYTES),
                       8'($urandom()));
        if ($urandom_range(0, 4) == 0) reg_read(IDX_COUNT);
        reg_write(IDX_COUNT, 32'(n));
        repeat (n + $urandom_range(0, 2)) pull_byte();
      end else if (pick < 65) begin
        repeat ((pending_q <= 40) ? int'(pending_q) + $urandom_range(1, 3) : 4) pull_byte();
      end else if (pick < 80) begin
        idx  = 3'($urandom_range(0, 7));
        data = $urandom();
        if (idx == IDX_COUNT) begin
          if (!late)
            data = $urandom_range(0, 16);
          else if ($urandom_range(0, 1) != 0)
            data = 32'(RING_BYTES - int'(pending_q) + $urandom_range(0, 2));
        end else if (idx == IDX_INIT && $urandom_range(0, 1) != 0) begin
          data = 32'd1;
        end
        reg_write(idx, data);
      end else if (pick < 92) begin
        reg_read(3'($urandom_range(0, 7)));
      end else if ($urandom_range(0, 1) != 0) begin
        sample_write(16'($urandom()), 8'($urandom()));
      end else begin
        pull_byte();
      end
    end
    idle_on <= 1'b1;
  endtask

  // result side stalls for a long stretch while requests keep coming
  task automatic test_input_backpressure();
    req.valid  <= 1'b0;
    hold_start <= 1'b1;
    idle_on    <= 1'b0;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (10) begin
      sample_write(16'((int'(play_ptr) + int'(pending_q)) % RING_BYTES), 8'($urandom()));
      reg_write(IDX_COUNT, 32'd1);
      pull_byte();
    end
    reg_read(IDX_SPARE_LO);
    idle_on <= 1'b1;
  endtask

  initial begin
    req.valid     = 1'b0;
    req.command   = CMD_REG_READ;
    req.reg_index = '0;
    req.reg_data  = '0;
    req.buf_addr  = '0;
    req.buf_byte  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_playback_gating();
    test_register_extremes();
    test_random_traffic();
    test_input_backpressure();

    req.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
